FILE: hdl/assert_macros.svh
// Assertion macros shared by the downmix resampler RTL.
// Included by every module that carries concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(name, ck, rs, ante, cons, msg) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pdnr_pkg.sv
// Shared types and constants for the downmix nearest-neighbor resampler.
// Used by the divider, the top level and the testbench; no dependencies.
package pdnr_pkg;

  localparam int SAMPLE_W     = 16;
  localparam int RATE_W       = 17;
  localparam int CH_W         = 4;
  localparam int MAX_CH       = 8;
  localparam int CH_POS_W     = $clog2(MAX_CH);
  localparam int SUM_W        = 20;
  localparam int MAX_FRAMES   = 16384;
  localparam int FRAME_W      = $clog2(MAX_FRAMES + 1);
  localparam int HIST_DEPTH   = 16;
  localparam int HIST_AW      = $clog2(HIST_DEPTH);
  localparam int RESULT_LIMIT = 12;
  localparam int CNT_W        = $clog2(RESULT_LIMIT + 1);
  localparam int POS_W        = 34;
  localparam int DIV_W        = POS_W;
  localparam int STEP_W       = $clog2(DIV_W + 1);
  localparam int CFG_IDX_W    = 2;

  localparam logic [RATE_W-1:0] RST_INPUT_RATE    = RATE_W'(44100);
  localparam logic [RATE_W-1:0] RST_OUTPUT_RATE   = RATE_W'(44100);
  localparam logic [CH_W-1:0]   RST_CHANNEL_COUNT = CH_W'(2);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INPUT_RATE    = 2'd0,
    CFG_OUTPUT_RATE   = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       buffer_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       run_last;
  } out_item_t;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;   // left aligned: the top 'steps' bits are divided
    logic [RATE_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [DIV_W-1:0]  quotient;
    logic [RATE_W-1:0] remainder;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MONO_WAIT,
    S_FRAME,
    S_POS_WAIT,
    S_STEP_WAIT,
    S_EMIT_ADDR,
    S_EMIT_LOAD,
    S_SKIP_WAIT,
    S_END,
    S_FALL_ADDR,
    S_FALL_LOAD
  } state_t;

endpackage

FILE: hdl/pcm_downmix_nearest_resampler.sv
// Mono downmix and nearest-neighbor resampler, sequenced around one shared serial divider.
// Sequence: a sample that does not close a frame is simply accepted. A frame-closing sample runs
// a 20-step mono divide plus, when output is due, a position divide and a step divide, one
// result load per output and one more divide when results beyond twelve are skipped.
// The divider is the pacing unit; one request is in flight at a time.
// Reset (synchronous, active high) restores the rate and channel registers and clears the buffer.
`include "assert_macros.svh"

module pcm_downmix_nearest_resampler (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  pdnr_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output pdnr_pkg::out_item_t                 out_data,
  input  logic                                cfg_write,
  input  logic [pdnr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [pdnr_pkg::RATE_W-1:0]         cfg_data
);

  // Configuration registers
  logic [pdnr_pkg::RATE_W-1:0]   input_rate;
  logic [pdnr_pkg::RATE_W-1:0]   output_rate;
  logic [pdnr_pkg::CH_W-1:0]     channel_count;

  // Buffer state
  pdnr_pkg::state_t              state;
  pdnr_pkg::state_t              state_next;
  logic signed [pdnr_pkg::SUM_W-1:0] channel_sum;
  logic [pdnr_pkg::CH_POS_W-1:0] channel_position;
  logic                          sum_neg;
  logic                          item_last;
  logic [pdnr_pkg::POS_W-1:0]    frame_bound;
  logic [pdnr_pkg::POS_W-1:0]    next_output_pos;
  logic [pdnr_pkg::FRAME_W-1:0]  frame_index;
  logic                          emitted_any;
  logic [pdnr_pkg::CNT_W-1:0]    result_count;

  // Source index tracking: next_output_pos / output_rate and input_rate / output_rate
  logic [pdnr_pkg::HIST_AW-1:0]  src_q;
  logic [pdnr_pkg::RATE_W-1:0]   src_r;
  logic [pdnr_pkg::HIST_AW-1:0]  step_q;
  logic [pdnr_pkg::RATE_W-1:0]   step_r;

  // Shared divider and history RAM
  pdnr_pkg::div_req_t            div_req;
  pdnr_pkg::div_rsp_t            div_rsp;
  logic                          ram_we;
  logic                          rd_zero;
  logic [pdnr_pkg::HIST_AW-1:0]  rd_addr;
  logic [pdnr_pkg::SAMPLE_W-1:0] rd_data;

  // Output register
  logic                          out_free;
  logic                          out_load;
  pdnr_pkg::out_item_t           out_next;
  logic                          clear_buf;

  // Combinational datapath
  logic                          in_fire;
  logic                          rates_ok;
  logic [pdnr_pkg::CH_W-1:0]     ch_eff;
  logic signed [pdnr_pkg::SUM_W-1:0] sum_next;
  logic [pdnr_pkg::SUM_W-1:0]    sum_mag;
  logic [pdnr_pkg::CH_W-1:0]     pos_inc;
  logic                          frame_done;
  logic                          frame_room;
  logic [pdnr_pkg::SAMPLE_W-1:0] mono_mag;
  logic [pdnr_pkg::SAMPLE_W-1:0] mono;
  logic [pdnr_pkg::POS_W-1:0]    fb_plus;
  logic [pdnr_pkg::POS_W:0]      nop_plus_in;
  logic                          due_frame;
  logic [pdnr_pkg::POS_W-1:0]    nop_n;
  logic [pdnr_pkg::POS_W:0]      nop_n_plus_in;
  logic                          due_n;
  logic [pdnr_pkg::RATE_W:0]     r_sum;
  logic                          wrap;
  logic [pdnr_pkg::RATE_W-1:0]   r_n;
  logic [pdnr_pkg::HIST_AW-1:0]  q_n;
  logic [pdnr_pkg::CNT_W-1:0]    count_n;
  logic                          more;
  logic                          fallback;

  pdnr_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  pdnr_ram #(
    .WIDTH (pdnr_pkg::SAMPLE_W),
    .DEPTH (pdnr_pkg::HIST_DEPTH)
  ) u_hist (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (frame_index[pdnr_pkg::HIST_AW-1:0]),
    .wr_data (mono),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Channel accumulation; channel counts above eight behave as eight
  assign in_fire    = in_valid && in_ready;
  assign rates_ok   = (input_rate != '0) && (output_rate != '0);
  assign ch_eff     = (channel_count > pdnr_pkg::CH_W'(pdnr_pkg::MAX_CH)) ?
                      pdnr_pkg::CH_W'(pdnr_pkg::MAX_CH) : channel_count;
  assign sum_next   = channel_sum + pdnr_pkg::SUM_W'(in_data.sample_in);
  assign sum_mag    = sum_next[pdnr_pkg::SUM_W-1] ? $unsigned(-sum_next) : $unsigned(sum_next);
  assign pos_inc    = pdnr_pkg::CH_W'(channel_position) + pdnr_pkg::CH_W'(1);
  assign frame_done = (ch_eff != '0) && (pos_inc >= ch_eff);
  assign frame_room = frame_index < pdnr_pkg::FRAME_W'(pdnr_pkg::MAX_FRAMES);

  // Mono sample: magnitude quotient with the sum's sign put back (truncates toward zero)
  assign mono_mag = div_rsp.quotient[pdnr_pkg::SAMPLE_W-1:0];
  assign mono     = sum_neg ? pdnr_pkg::SAMPLE_W'(-mono_mag) : mono_mag;

  // Output index is due while next_output_pos + input_rate <= frame_bound
  assign fb_plus       = frame_bound + pdnr_pkg::POS_W'(output_rate);
  assign nop_plus_in   = {1'b0, next_output_pos} + (pdnr_pkg::POS_W+1)'(input_rate);
  assign due_frame     = nop_plus_in <= {1'b0, fb_plus};
  assign nop_n         = nop_plus_in[pdnr_pkg::POS_W-1:0];
  assign nop_n_plus_in = {1'b0, nop_n} + (pdnr_pkg::POS_W+1)'(input_rate);
  assign due_n         = nop_n_plus_in <= {1'b0, frame_bound};

  // Advance the source index by input_rate / output_rate with one remainder correction
  assign r_sum   = {1'b0, src_r} + {1'b0, step_r};
  assign wrap    = r_sum >= {1'b0, output_rate};
  assign r_n     = wrap ? pdnr_pkg::RATE_W'(r_sum - {1'b0, output_rate}) :
                          r_sum[pdnr_pkg::RATE_W-1:0];
  assign q_n     = src_q + step_q + pdnr_pkg::HIST_AW'(wrap);
  assign count_n = result_count + pdnr_pkg::CNT_W'(1);
  assign more    = (count_n < pdnr_pkg::CNT_W'(pdnr_pkg::RESULT_LIMIT)) && due_n;

  // A buffer that took frames but emitted nothing repeats its first frame at its end, if both rates are nonzero
  assign fallback = !emitted_any && (frame_index != '0) && rates_ok;

  assign out_free = !out_valid || out_ready;
  assign rd_addr  = rd_zero ? '0 : src_q;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      pdnr_pkg::S_IDLE: begin
        if (in_fire) begin
          if (frame_done) begin
            state_next = pdnr_pkg::S_MONO_WAIT;
          end else if (in_data.buffer_end) begin
            state_next = pdnr_pkg::S_END;
          end
        end
      end
      pdnr_pkg::S_MONO_WAIT: begin
        if (div_rsp.done) begin
          state_next = pdnr_pkg::S_FRAME;
        end
      end
      pdnr_pkg::S_FRAME: begin
        if (frame_room && rates_ok && due_frame) begin
          state_next = pdnr_pkg::S_POS_WAIT;
        end else begin
          state_next = item_last ? pdnr_pkg::S_END : pdnr_pkg::S_IDLE;
        end
      end
      pdnr_pkg::S_POS_WAIT: begin
        if (div_rsp.done) begin
          state_next = pdnr_pkg::S_STEP_WAIT;
        end
      end
      pdnr_pkg::S_STEP_WAIT: begin
        if (div_rsp.done) begin
          state_next = pdnr_pkg::S_EMIT_ADDR;
        end
      end
      pdnr_pkg::S_EMIT_ADDR: begin
        state_next = pdnr_pkg::S_EMIT_LOAD;
      end
      pdnr_pkg::S_EMIT_LOAD: begin
        if (out_free) begin
          if (more) begin
            state_next = pdnr_pkg::S_EMIT_ADDR;
          end else if (due_n) begin
            state_next = pdnr_pkg::S_SKIP_WAIT;
          end else begin
            state_next = item_last ? pdnr_pkg::S_END : pdnr_pkg::S_IDLE;
          end
        end
      end
      pdnr_pkg::S_SKIP_WAIT: begin
        if (div_rsp.done) begin
          state_next = item_last ? pdnr_pkg::S_END : pdnr_pkg::S_IDLE;
        end
      end
      pdnr_pkg::S_END: begin
        state_next = fallback ? pdnr_pkg::S_FALL_ADDR : pdnr_pkg::S_IDLE;
      end
      pdnr_pkg::S_FALL_ADDR: begin
        state_next = pdnr_pkg::S_FALL_LOAD;
      end
      pdnr_pkg::S_FALL_LOAD: begin
        if (out_free) begin
          state_next = pdnr_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pdnr_pkg::S_IDLE;
      end
    endcase
  end

  // Sequencer outputs: divider requests, history access, result loads
  always_comb begin
    in_ready             = 1'b0;
    div_req              = '0;
    ram_we               = 1'b0;
    rd_zero              = 1'b0;
    out_load             = 1'b0;
    clear_buf            = 1'b0;
    out_next.sample_out  = rd_data;
    out_next.run_last    = 1'b1;
    unique case (state)
      pdnr_pkg::S_IDLE: begin
        in_ready = 1'b1;
        // Divide the channel sum magnitude by the channel count
        if (in_fire && frame_done) begin
          div_req.start    = 1'b1;
          div_req.dividend = pdnr_pkg::DIV_W'(sum_mag) << (pdnr_pkg::DIV_W - pdnr_pkg::SUM_W);
          div_req.divisor  = pdnr_pkg::RATE_W'(ch_eff);
          div_req.steps    = pdnr_pkg::STEP_W'(pdnr_pkg::SUM_W);
        end
      end
      pdnr_pkg::S_FRAME: begin
        ram_we = frame_room;
        // Source frame of the first due output: next_output_pos / output_rate
        if (frame_room && rates_ok && due_frame) begin
          div_req.start    = 1'b1;
          div_req.dividend = next_output_pos;
          div_req.divisor  = output_rate;
          div_req.steps    = pdnr_pkg::STEP_W'(pdnr_pkg::DIV_W);
        end
      end
      pdnr_pkg::S_POS_WAIT: begin
        // Per-output source step: input_rate / output_rate
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = pdnr_pkg::DIV_W'(input_rate) << (pdnr_pkg::DIV_W - pdnr_pkg::RATE_W);
          div_req.divisor  = output_rate;
          div_req.steps    = pdnr_pkg::STEP_W'(pdnr_pkg::RATE_W);
        end
      end
      pdnr_pkg::S_EMIT_LOAD: begin
        if (out_free) begin
          out_load          = 1'b1;
          out_next.run_last = !more;
          // Result limit hit with outputs still due: drop them, keep the position in step
          if (!more && due_n) begin
            div_req.start    = 1'b1;
            div_req.dividend = frame_bound - nop_n_plus_in[pdnr_pkg::POS_W-1:0];
            div_req.divisor  = input_rate;
            div_req.steps    = pdnr_pkg::STEP_W'(pdnr_pkg::DIV_W);
          end
        end
      end
      pdnr_pkg::S_END: begin
        clear_buf = !fallback;
      end
      pdnr_pkg::S_FALL_ADDR: begin
        rd_zero = 1'b1;
      end
      pdnr_pkg::S_FALL_LOAD: begin
        rd_zero   = 1'b1;
        out_load  = out_free;
        clear_buf = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= pdnr_pkg::S_IDLE;
      input_rate       <= pdnr_pkg::RST_INPUT_RATE;
      output_rate      <= pdnr_pkg::RST_OUTPUT_RATE;
      channel_count    <= pdnr_pkg::RST_CHANNEL_COUNT;
      channel_sum      <= '0;
      channel_position <= '0;
      frame_bound      <= '0;
      next_output_pos  <= '0;
      frame_index      <= '0;
      emitted_any      <= 1'b0;
      result_count     <= '0;
      out_valid        <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_write) begin
        unique case (cfg_index)
          pdnr_pkg::CFG_INPUT_RATE:    input_rate    <= cfg_data;
          pdnr_pkg::CFG_OUTPUT_RATE:   output_rate   <= cfg_data;
          pdnr_pkg::CFG_CHANNEL_COUNT: channel_count <= cfg_data[pdnr_pkg::CH_W-1:0];
          default: begin
          end
        endcase
      end

      // Accumulate channels; drop samples when the channel count is zero
      if (in_fire && ch_eff != '0) begin
        if (frame_done) begin
          channel_sum      <= '0;
          channel_position <= '0;
        end else begin
          channel_sum      <= sum_next;
          channel_position <= pos_inc[pdnr_pkg::CH_POS_W-1:0];
        end
      end

      if (state == pdnr_pkg::S_FRAME) begin
        result_count <= '0;
        if (frame_room) begin
          frame_index <= frame_index + pdnr_pkg::FRAME_W'(1);
          if (rates_ok) begin
            frame_bound <= fb_plus;
          end
        end
      end

      if (state == pdnr_pkg::S_EMIT_LOAD && out_free) begin
        next_output_pos <= nop_n;
        result_count    <= count_n;
        emitted_any     <= 1'b1;
      end

      // Skip past the last due index: frame_bound minus the leftover remainder
      if (state == pdnr_pkg::S_SKIP_WAIT && div_rsp.done) begin
        next_output_pos <= frame_bound - pdnr_pkg::POS_W'(div_rsp.remainder);
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (clear_buf) begin
        channel_sum      <= '0;
        channel_position <= '0;
        frame_bound      <= '0;
        next_output_pos  <= '0;
        frame_index      <= '0;
        emitted_any      <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      item_last <= in_data.buffer_end;
      sum_neg   <= sum_next[pdnr_pkg::SUM_W-1];
    end
    if (state == pdnr_pkg::S_POS_WAIT && div_rsp.done) begin
      src_q <= div_rsp.quotient[pdnr_pkg::HIST_AW-1:0];
      src_r <= div_rsp.remainder;
    end
    if (state == pdnr_pkg::S_STEP_WAIT && div_rsp.done) begin
      step_q <= div_rsp.quotient[pdnr_pkg::HIST_AW-1:0];
      step_r <= div_rsp.remainder;
    end
    if (state == pdnr_pkg::S_EMIT_LOAD && out_free) begin
      src_q <= q_n;
      src_r <= r_n;
    end
    if (out_load) begin
      out_data <= out_next;
    end
  end

  `ASSERT_IMPLY(a_no_overwrite, clk, rst, out_load, !out_valid || out_ready, "result overwritten")
  `ASSERT_IMPLY(a_count_limit, clk, rst, 1'b1, result_count <= pdnr_pkg::RESULT_LIMIT, "too many results")
  `ASSERT_IMPLY(a_emit_has_frame, clk, rst, emitted_any, frame_index != '0, "output without a frame")
  `ASSERT_IMPLY(a_wait_has_div, clk, rst, state == pdnr_pkg::S_MONO_WAIT || state == pdnr_pkg::S_POS_WAIT || state == pdnr_pkg::S_STEP_WAIT || state == pdnr_pkg::S_SKIP_WAIT, div_rsp.busy || div_rsp.done, "waiting on an idle divider")

endmodule

FILE: hdl/pdnr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Holds the mono history; no dependencies.
module pdnr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: hdl/pdnr_div.sv
// Shared restoring divider, one quotient bit per cycle while busy.
// Depends on pdnr_pkg (request/response structs) and assert_macros.svh.
`include "assert_macros.svh"

module pdnr_div (
  input  logic               clk,
  input  logic               rst,
  input  pdnr_pkg::div_req_t req,
  output pdnr_pkg::div_rsp_t rsp
);

  logic                              busy;
  logic                              done;
  logic [pdnr_pkg::STEP_W-1:0]       cnt;
  logic [pdnr_pkg::DIV_W-1:0]        dvd;
  logic [pdnr_pkg::RATE_W-1:0]       rem;
  logic [pdnr_pkg::RATE_W-1:0]       dsr;
  logic [pdnr_pkg::RATE_W:0]         partial;
  logic [pdnr_pkg::RATE_W+1:0]       diff;
  logic                              ge;
  logic [pdnr_pkg::RATE_W-1:0]       rem_next;

  // Shift the next dividend bit into the partial remainder and trial-subtract.
  assign partial  = {rem, dvd[pdnr_pkg::DIV_W-1]};
  assign diff     = {1'b0, partial} - {2'b00, dsr};
  assign ge       = !diff[pdnr_pkg::RATE_W+1];
  assign rem_next = ge ? diff[pdnr_pkg::RATE_W-1:0] : partial[pdnr_pkg::RATE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.steps;
      end else if (busy) begin
        cnt <= cnt - pdnr_pkg::STEP_W'(1);
        if (cnt == pdnr_pkg::STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      dvd <= {dvd[pdnr_pkg::DIV_W-2:0], ge};
      rem <= rem_next;
    end
  end

  assign rsp.busy      = busy;
  assign rsp.done      = done;
  assign rsp.quotient  = dvd;
  assign rsp.remainder = rem;

  `ASSERT_IMPLY(a_start_when_idle, clk, rst, req.start, !busy, "divider restarted while busy")
  `ASSERT_IMPLY(a_done_follows_busy, clk, rst, done, $past(busy), "done without a running divide")
  `ASSERT_IMPLY(a_rem_below_divisor, clk, rst, done && dsr != '0, rem < dsr, "remainder not reduced")

endmodule

FILE: test/pdnr_checker.sv
// Result checker for the downmix resampler: watches the request, result and register ports,
// predicts every mono result from its own copy of the block state and compares in order.
// Depends on pdnr_pkg for the payload types, widths and register indexes.
module pdnr_checker
  import pdnr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  in_item_t             in_data,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  out_item_t            out_data,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RATE_W-1:0]    cfg_data,
  output int                   mismatches,
  output int                   pending,
  output int                   compared
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [RATE_W-1:0]   src_rate;
  logic [RATE_W-1:0]   dst_rate;
  logic [CH_W-1:0]     chan_cfg;
  int                  chan_acc;
  int                  chan_seen;
  longint unsigned     frame_bound;
  longint unsigned     next_pos;
  int                  frames_in_buf;
  logic [SAMPLE_W-1:0] mono_ring [HIST_DEPTH];
  bit                  buf_emitted;
  out_item_t           due_samples [$];
  int                  bad_count;
  int                  seen_count;

  task automatic clear_buffer();
    chan_acc      = 0;
    chan_seen     = 0;
    frame_bound   = 0;
    next_pos      = 0;
    frames_in_buf = 0;
    buf_emitted   = 1'b0;
  endtask

  // Downmix one sample; when it closes a frame, queue the output indices now due, at most RESULT_LIMIT.
  task automatic downmix_resample(input in_item_t req);
    out_item_t       batch [RESULT_LIMIT];
    int              n;
    int              k;
    int              chans;
    int              mono;
    longint unsigned src;
    longint unsigned skip;
    bit              rates_ok;
    n = 0;
    rates_ok = (src_rate != 0) && (dst_rate != 0);
    chans = (chan_cfg > MAX_CH) ? MAX_CH : int'(chan_cfg);
    if (chans != 0) begin
      chan_acc += int'($signed(req.sample_in));
      chan_seen++;
      if (chan_seen >= chans) begin
        mono = chan_acc / chans;
        chan_acc = 0;
        chan_seen = 0;
        if (frames_in_buf < MAX_FRAMES) begin
          mono_ring[frames_in_buf % HIST_DEPTH] = SAMPLE_W'(mono);
          frames_in_buf++;
          if (rates_ok) begin
            frame_bound += dst_rate;
            while (n < RESULT_LIMIT && next_pos + src_rate <= frame_bound) begin
              src = next_pos / dst_rate;
              batch[n].sample_out = mono_ring[src % HIST_DEPTH];
              batch[n].run_last = 1'b0;
              n++;
              buf_emitted = 1'b1;
              next_pos += src_rate;
            end
            // indices past the per-frame cap are dropped but still consumed
            if (next_pos + src_rate <= frame_bound) begin
              skip = (frame_bound - next_pos - src_rate) / src_rate + 1;
              next_pos += skip * src_rate;
            end
          end
        end
      end
    end
    if (req.buffer_end) begin
      if (!buf_emitted && frames_in_buf > 0 && rates_ok) begin
        batch[n].sample_out = mono_ring[0];
        batch[n].run_last = 1'b0;
        n++;
      end
      clear_buffer();
    end
    if (n > 0) batch[n-1].run_last = 1'b1;
    for (k = 0; k < n; k++) due_samples.push_back(batch[k]);
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (due_samples.size() == 0) begin
      bad_count++;
      if (bad_count <= 10)
        $display("[%0t] unexpected result: sample_out=%0d run_last=%0b",
                 $time, got.sample_out, got.run_last);
    end else begin
      want = due_samples.pop_front();
      seen_count++;
      if (got.sample_out !== want.sample_out || got.run_last !== want.run_last) begin
        bad_count++;
        if (bad_count <= 10)
          $display("[%0t] result %0d: expected sample_out=%0d run_last=%0b, got %0d/%0b",
                   $time, seen_count, want.sample_out, want.run_last,
                   got.sample_out, got.run_last);
      end
    end
  endtask

  initial begin
    bad_count  = 0;
    seen_count = 0;
    mismatches = 0;
    pending    = 0;
    compared   = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      src_rate = RST_INPUT_RATE;
      dst_rate = RST_OUTPUT_RATE;
      chan_cfg = RST_CHANNEL_COUNT;
      clear_buffer();
      due_samples.delete();
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (cfg_write) begin
        case (cfg_index)
          CFG_INPUT_RATE:    src_rate = cfg_data;
          CFG_OUTPUT_RATE:   dst_rate = cfg_data;
          CFG_CHANNEL_COUNT: chan_cfg = cfg_data[CH_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) downmix_resample(in_data);
    end
    mismatches <= bad_count;
    pending    <= due_samples.size();
    compared   <= seen_count;
  end

endmodule

FILE: test/tb_pcm_downmix_nearest_resampler.sv
// Top of the downmix resampler testbench: clock, reset, request and register stimulus, result
// sink and verdict. Depends on pdnr_pkg, pdnr_checker and the block itself.
module tb_pcm_downmix_nearest_resampler;
  timeunit 1ns;
  timeprecision 1ps;
  import pdnr_pkg::*;

  // Index 3 decodes to no register; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT   = 20000;
  localparam int SETTLE_CYCLES    = 200;   // worst frame: divide + emits + skip, with margin
  localparam int HOLD_CYCLES      = 300;
  localparam int N_SETTINGS       = 14;
  localparam int PRESSURE_SETTING = 2;     // 12 results per frame, so the block backs up fast
  localparam int OVERFLOW_FRAMES  = MAX_FRAMES + 24;

  logic                 clk;
  logic                 rst       = 1'b1;
  logic                 in_valid  = 1'b0;
  logic                 in_ready;
  in_item_t             in_data   = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  out_item_t            out_data;
  logic                 cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_INPUT_RATE;
  logic [RATE_W-1:0]    cfg_data  = '0;

  int mismatches;
  int pending;
  int compared;

  // Idle controls set by the stimulus: tx_gaps for the request driver, rx_gaps and hold_off for the sink.
  bit tx_gaps  = 1'b0;
  bit rx_gaps  = 1'b0;
  bit hold_off = 1'b0;

  int tb_chans;     // effective channels per frame under the current setting
  int sent;
  int buffers;
  int n_settings;

  pcm_downmix_nearest_resampler dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  pdnr_checker results_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .compared   (compared)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request; hold valid and payload until the block takes it.
  task automatic push_sample(input logic signed [SAMPLE_W-1:0] value, input logic last);
    if (tx_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{sample_in: value, buffer_end: last};
    do @(posedge clk); while (!in_ready);
    sent++;
    if (last) buffers++;
  endtask

  // Mostly random codes, with the two rails showing up often.
  function automatic logic signed [SAMPLE_W-1:0] any_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Drop valid, let every expected result drain, then give a frame that produced
  // nothing time to finish before anything else touches the registers.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all three registers, plus a junk write to the undecoded index.
  // Channel count sits in the low bits; fill the rest with noise the block must mask.
  task automatic program_rates(input logic [RATE_W-1:0] r_in, input logic [RATE_W-1:0] r_out,
                               input logic [CH_W-1:0] chans);
    wait_drained();
    cfg_write <= 1'b1;
    cfg_index <= CFG_INPUT_RATE;
    cfg_data  <= r_in;
    @(posedge clk);
    cfg_index <= CFG_OUTPUT_RATE;
    cfg_data  <= r_out;
    @(posedge clk);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data  <= {(RATE_W-CH_W)'($urandom), chans};
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= RATE_W'($urandom);
    @(posedge clk);
    cfg_write <= 1'b0;
    tb_chans = (chans > MAX_CH) ? MAX_CH : int'(chans);
    n_settings++;
  endtask

  // One buffer: whole frames, optionally a trailing partial frame, end flag on the last.
  task automatic play_buffer(input int frames, input int extra);
    int total;
    int i;
    total = frames * tb_chans + extra;
    for (i = 0; i < total; i++) push_sample(any_sample(), i == total - 1);
  endtask

  // Rate table for the random part. Rows past the table draw in-range settings.
  task automatic pick_setting(input int idx, output int unsigned r_in, output int unsigned r_out,
                              output int unsigned chans, output int max_frames,
                              output int budget);
    max_frames = 8;
    budget     = 36;
    case (idx)
      0:  begin r_in = 44100;  r_out = 48000;  chans = 2; end
      1:  begin r_in = 48000;  r_out = 44100;  chans = 2; end
      2:  begin r_in = 8000;   r_out = 96000;  chans = 1; max_frames = 6; end
      3:  begin r_in = 96000;  r_out = 8000;   chans = 3; max_frames = 20; budget = 60; end
      4:  begin r_in = 96000;  r_out = 96000;  chans = 1; end
      5:  begin r_in = 8000;   r_out = 8000;   chans = 8; max_frames = 4; end
      6:  begin r_in = 22050;  r_out = 44100;  chans = 4; max_frames = 6; end
      // one output per twenty frames: the source frame falls out of the history window
      7:  begin r_in = 2000;   r_out = 100;    chans = 1; max_frames = 60; budget = 120; end
      // thirteen indices due per frame, one dropped each time
      8:  begin r_in = 1;      r_out = 13;     chans = 1; max_frames = 4; budget = 24; end
      9:  begin r_in = 44100;  r_out = 0;      chans = 2; max_frames = 6; end
      10: begin r_in = 131071; r_out = 131071; chans = 3; max_frames = 6; end
      11: begin r_in = 32000;  r_out = 48000;  chans = 6; max_frames = 5; end
      default: begin
        r_in  = $urandom_range(8000, 96000);
        r_out = $urandom_range(8000, 96000);
        chans = $urandom_range(1, 8);
      end
    endcase
  endtask

  // Result sink: random stalls, one long hold-off on request, nothing else.
  initial begin : sink
    wait (!rst);
    forever begin
      if (hold_off) begin
        hold_off = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (rx_gaps && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Abort when no handshake or register write happens for too long.
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
             WATCHDOG_LIMIT, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    int unsigned r_in;
    int unsigned r_out;
    int unsigned chans;
    int          max_frames;
    int          budget;
    int          start;
    int          frames;
    int          s;
    int          i;
    sent       = 0;
    buffers    = 0;
    n_settings = 0;
    tb_chans   = 2;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // ---- directed part ----
    // Equal rates, stereo: both rails, truncation toward zero on a negative odd sum,
    // a zero result, then a dangling half frame that must vanish at the end flag.
    program_rates(44100, 44100, 2);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh7FFF, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(16'sh8000, 1'b0);
    push_sample(-16'sd3, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(-16'sd1, 1'b0);
    push_sample(16'sd0, 1'b0);
    push_sample(16'sd7, 1'b1);

    // Zero channels: samples ignored, end flag still closes an empty buffer.
    program_rates(44100, 44100, 0);
    push_sample(16'sd100, 1'b0);
    push_sample(-16'sd100, 1'b0);
    push_sample(16'sd5, 1'b1);

    // Channel count above eight behaves as eight; mixed rails in one frame.
    program_rates(44100, 44100, 15);
    for (i = 0; i < 8; i++) push_sample((i < 4) ? 16'sh7FFF : 16'sh8000, i == 7);

    // Zero input rate: frames accepted, nothing out, not even the fallback.
    program_rates(0, 44100, 1);
    push_sample(16'sd1, 1'b0);
    push_sample(16'sd2, 1'b1);

    // Short buffer at a 12:1 decimation: no index comes due, end emits frame 0.
    program_rates(96000, 8000, 1);
    push_sample(-16'sd1234, 1'b0);
    push_sample(16'sd77, 1'b0);
    push_sample(16'sd5, 1'b1);

    // More than twelve indices due in the second frame: cap hits, the excess is skipped.
    program_rates(8000, 100000, 1);
    push_sample(16'sd4321, 1'b0);
    push_sample(-16'sd4321, 1'b1);

    // ---- frame overflow: one buffer longer than the frame counter allows ----
    program_rates(96000, 8000, 1);
    for (i = 0; i < OVERFLOW_FRAMES; i++) push_sample(any_sample(), i == OVERFLOW_FRAMES - 1);

    // ---- random part ----
    for (s = 0; s < N_SETTINGS; s++) begin
      pick_setting(s, r_in, r_out, chans, max_frames, budget);
      program_rates(RATE_W'(r_in), RATE_W'(r_out), CH_W'(chans));
      // the final setting runs with no idling on either side
      tx_gaps = (s != N_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
      rx_gaps = (s != N_SETTINGS - 1) && ($urandom_range(0, 3) != 0);
      if (s == PRESSURE_SETTING) begin
        // keep offering requests back to back while the sink sits on its ready
        tx_gaps = 1'b0;
        hold_off = 1'b1;
      end
      start = sent;
      while (sent - start < budget) begin
        frames = $urandom_range(1, max_frames);
        case ($urandom_range(0, 9))
          0: push_sample(any_sample(), 1'b1);   // stray end flag, at most a partial frame
          1: play_buffer(frames, (tb_chans > 1) ? $urandom_range(1, tb_chans - 1) : 0);
          default: play_buffer(frames, 0);
        endcase
      end
    end

    // ---- wrap up ----
    wait_drained();
    $display("Ran %0d requests in %0d buffers over %0d register settings,", sent, buffers,
             n_settings);
    $display("including a %0d-frame overflow buffer; %0d results compared, %0d mismatches.",
             OVERFLOW_FRAMES, compared, mismatches);
    if (mismatches == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
